>>> src/ugsq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the grid segment query.
`timescale 1ns / 1ps
`default_nettype none
package ugsq_pkg;

    localparam int DEF_MAX_WALLS  = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int QUERY_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int STEP_W    = 16;
    localparam int CMD_W     = 2;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd64;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 1'b1;

    // Division jobs of a query
    localparam int JOB_W = 4;
    localparam logic [JOB_W-1:0] JOB_LAST_X = 4'd0;
    localparam logic [JOB_W-1:0] JOB_C0_X   = 4'd1;
    localparam logic [JOB_W-1:0] JOB_C1_X   = 4'd2;
    localparam logic [JOB_W-1:0] JOB_LAST_Y = 4'd3;
    localparam logic [JOB_W-1:0] JOB_C0_Y   = 4'd4;
    localparam logic [JOB_W-1:0] JOB_C1_Y   = 4'd5;
    localparam logic [JOB_W-1:0] JOB_WMN_X  = 4'd6;
    localparam logic [JOB_W-1:0] JOB_WMX_X  = 4'd7;
    localparam logic [JOB_W-1:0] JOB_WMN_Y  = 4'd8;
    localparam logic [JOB_W-1:0] JOB_WMX_Y  = 4'd9;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic             unbuild;
        logic             build_start;
        logic             box_upd;
        logic             build_done;
        logic             q_latch;
        logic             div_start;
        logic             cap;
        logic [JOB_W-1:0] job;
        logic             wall_wr;
        logic             scan_init;
        logic             scan_cmp;
        logic             emit_hit;
        logic             emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_end;
        logic steps_ok;
        logic query_ok;
        logic div_busy;
        logic npend_zero;
        logic last_one;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> src/uniform_grid_segment_query.sv
// Top level: uniform grid broad phase over stored wall segments, answering circle queries.
// Clear, load and a build with a zero step are done in the idle state; a build reads each of the N walls.
// A query's time is set by the bit-serial divider, 25 bits wide by default, run for each cell
// bound and each wall bound, and by the key scan, run once for each wall returned.
// One item is worked on at a time; a result waits in the output register while the next
// item is taken. Synchronous active-low reset clears control state and sets both steps to 64.
`timescale 1ns / 1ps
`default_nettype none
module uniform_grid_segment_query #(
    parameter int MAX_WALLS  = ugsq_pkg::DEF_MAX_WALLS,
    parameter int COORD_BITS = ugsq_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = ugsq_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ugsq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ugsq_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [ugsq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [COORD_BITS-1:0]          i_wall_x1,
    input  wire logic [COORD_BITS-1:0]          i_wall_y1,
    input  wire logic [COORD_BITS-1:0]          i_wall_x2,
    input  wire logic [COORD_BITS-1:0]          i_wall_y2,
    input  wire logic [ugsq_pkg::QUERY_W-1:0]   i_query_x,
    input  wire logic [ugsq_pkg::QUERY_W-1:0]   i_query_y,
    input  wire logic [ugsq_pkg::RADIUS_W-1:0]  i_query_radius,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [ugsq_pkg::OUT_IDX_W-1:0]      o_wall_index,
    output logic                                o_found,
    output logic                                o_overflowed,
    output logic                                o_last
);
    // Commands down to the datapath, status back up to the controller
    ugsq_pkg::t_dp_cmd  dp_cmd;
    ugsq_pkg::t_dp_stat dp_stat;

    // The controller takes a transfer only in its idle state
    ugsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath: stores, box, cell ranges by division, emission scan and result register
    ugsq_dp #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_wall_x1      (i_wall_x1),
        .i_wall_y1      (i_wall_y1),
        .i_wall_x2      (i_wall_x2),
        .i_wall_y2      (i_wall_y2),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_radius (i_query_radius),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_wall_index   (o_wall_index),
        .o_found        (o_found),
        .o_overflowed   (o_overflowed),
        .o_last         (o_last)
    );
endmodule
`default_nettype wire

>>> src/ugsq_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ugsq_div #(
    parameter int DW = 25,
    parameter int SW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [SW-1:0] i_den,
    output logic               o_busy,
    output logic [DW-1:0]      o_quo
);
    localparam int CTW = $clog2(DW + 1);

    logic [CTW-1:0] r_cnt;
    logic [DW-1:0]  r_num;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_den;
    logic [SW:0]    sh;
    logic [SW:0]    diff;
    logic           ge;

    assign sh   = {r_rem, r_num[DW-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = !diff[SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[SW-1:0] : sh[SW-1:0];
            r_num <= {r_num[DW-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_num;
endmodule
`default_nettype wire

>>> src/ugsq_ctrl.sv
// Controller state machine: sequences build, cell range, per-wall and emission passes.
`timescale 1ns / 1ps
`default_nettype none
module ugsq_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [ugsq_pkg::CMD_W-1:0] i_command,
    input  wire ugsq_pkg::t_dp_stat        i_stat,
    output ugsq_pkg::t_dp_cmd              o_cmd
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_B_RD      = 4'd1;
    localparam logic [3:0] S_B_UPD     = 4'd2;
    localparam logic [3:0] S_DIV_START = 4'd3;
    localparam logic [3:0] S_DIV_RUN   = 4'd4;
    localparam logic [3:0] S_DIV_CAP   = 4'd5;
    localparam logic [3:0] S_W_RD      = 4'd6;
    localparam logic [3:0] S_W_WR      = 4'd7;
    localparam logic [3:0] S_S_RD      = 4'd8;
    localparam logic [3:0] S_S_CMP     = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;
    localparam logic [3:0] S_EMPTY     = 4'd11;

    logic [3:0]                    r_state, n_state;
    logic [ugsq_pkg::JOB_W-1:0]    r_job, n_job;
    logic                          accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        o_cmd   = '0;
        o_cmd.job = r_job;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        ugsq_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                        ugsq_pkg::CMD_LOAD:  o_cmd.load  = 1'b1;
                        ugsq_pkg::CMD_BUILD: begin
                            if (i_stat.steps_ok) begin
                                o_cmd.build_start = 1'b1;
                                n_state = S_B_RD;
                            end else begin
                                o_cmd.unbuild = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.q_latch = 1'b1;
                            if (i_stat.query_ok) begin
                                n_job   = ugsq_pkg::JOB_LAST_X;
                                n_state = S_DIV_START;
                            end else begin
                                n_state = S_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_B_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.build_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_UPD;
                end
            end
            S_B_UPD: begin
                o_cmd.box_upd = 1'b1;
                n_state = S_B_RD;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DIV_CAP;
                end
            end
            S_DIV_CAP: begin
                o_cmd.cap = 1'b1;
                n_state = S_DIV_START;
                case (r_job)
                    ugsq_pkg::JOB_LAST_X: n_job = ugsq_pkg::JOB_C0_X;
                    ugsq_pkg::JOB_C0_X:   n_job = ugsq_pkg::JOB_C1_X;
                    ugsq_pkg::JOB_C1_X:   n_job = ugsq_pkg::JOB_LAST_Y;
                    ugsq_pkg::JOB_LAST_Y: n_job = ugsq_pkg::JOB_C0_Y;
                    ugsq_pkg::JOB_C0_Y:   n_job = ugsq_pkg::JOB_C1_Y;
                    ugsq_pkg::JOB_C1_Y:   n_state = S_W_RD;
                    ugsq_pkg::JOB_WMN_X:  n_job = ugsq_pkg::JOB_WMX_X;
                    ugsq_pkg::JOB_WMX_X:  n_job = ugsq_pkg::JOB_WMN_Y;
                    ugsq_pkg::JOB_WMN_Y:  n_job = ugsq_pkg::JOB_WMX_Y;
                    default:              n_state = S_W_WR;
                endcase
            end
            S_W_RD: begin
                if (i_stat.idx_end) begin
                    if (i_stat.npend_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_S_RD;
                    end
                end else begin
                    n_job   = ugsq_pkg::JOB_WMN_X;
                    n_state = S_DIV_START;
                end
            end
            S_W_WR: begin
                o_cmd.wall_wr = 1'b1;
                n_state = S_W_RD;
            end
            S_S_RD: begin
                n_state = i_stat.idx_end ? S_EMIT : S_S_CMP;
            end
            S_S_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = S_S_RD;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_hit = 1'b1;
                    if (i_stat.last_one) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_S_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= ugsq_pkg::JOB_LAST_X;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end
endmodule
`default_nettype wire

>>> src/ugsq_dp.sv
// Datapath: wall and key stores, box, step registers, cell arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module ugsq_dp #(
    parameter int MAX_WALLS  = ugsq_pkg::DEF_MAX_WALLS,
    parameter int COORD_BITS = ugsq_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = ugsq_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ugsq_pkg::t_dp_cmd              i_cmd,
    output ugsq_pkg::t_dp_stat                  o_stat,
    input  wire logic                           i_cfg_we,
    input  wire logic [ugsq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ugsq_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  wire logic [COORD_BITS-1:0]          i_wall_x1,
    input  wire logic [COORD_BITS-1:0]          i_wall_y1,
    input  wire logic [COORD_BITS-1:0]          i_wall_x2,
    input  wire logic [COORD_BITS-1:0]          i_wall_y2,
    input  wire logic [ugsq_pkg::QUERY_W-1:0]   i_query_x,
    input  wire logic [ugsq_pkg::QUERY_W-1:0]   i_query_y,
    input  wire logic [ugsq_pkg::RADIUS_W-1:0]  i_query_radius,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic [ugsq_pkg::OUT_IDX_W-1:0]      o_wall_index,
    output logic                                o_found,
    output logic                                o_overflowed,
    output logic                                o_last
);
    localparam int CW   = COORD_BITS;
    localparam int IW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNTW = $clog2(MAX_WALLS + 1);
    localparam int SW   = ugsq_pkg::STEP_W + FRAC_BITS;
    localparam int DW   = ((ugsq_pkg::QUERY_W > CW + FRAC_BITS) ?
                           ugsq_pkg::QUERY_W : CW + FRAC_BITS) + 1;
    localparam int WW   = DW + 1;

    // Stores
    logic [4*CW-1:0] mem_wall [MAX_WALLS];
    logic [2*CW-1:0] mem_key  [MAX_WALLS];
    logic [4*CW-1:0] r_rd;
    logic [2*CW-1:0] r_kd;

    logic [CNTW-1:0] r_count, r_idx, r_npend;
    logic [MAX_WALLS-1:0] r_pend;
    logic            r_built, r_drop;
    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [ugsq_pkg::STEP_W-1:0] r_step_x, r_step_y;

    logic signed [ugsq_pkg::QUERY_W-1:0] r_qx, r_qy;
    logic [ugsq_pkg::RADIUS_W-1:0]       r_qr;

    logic signed [WW-1:0] r_last_x, r_last_y, r_c0_x, r_c0_y, r_c1_x, r_c1_y;
    logic signed [WW-1:0] r_wfirst, r_fx, r_fy;
    logic                 r_okx, r_oky, r_neg;

    logic [2*CW-1:0] r_best_key;
    logic [IW-1:0]   r_best_idx;
    logic            r_best_ok;

    logic full;
    assign full = (r_count == CNTW'(MAX_WALLS));

    // Wall coordinates of the entry being read
    logic signed [CW-1:0] w_x1, w_y1, w_x2, w_y2, bx_lo, bx_hi, by_lo, by_hi;
    assign w_x1  = r_rd[4*CW-1:3*CW];
    assign w_y1  = r_rd[3*CW-1:2*CW];
    assign w_x2  = r_rd[2*CW-1:CW];
    assign w_y2  = r_rd[CW-1:0];
    assign bx_lo = (w_x1 < w_x2) ? w_x1 : w_x2;
    assign bx_hi = (w_x1 < w_x2) ? w_x2 : w_x1;
    assign by_lo = (w_y1 < w_y2) ? w_y1 : w_y2;
    assign by_hi = (w_y1 < w_y2) ? w_y2 : w_y1;

    // Operand selection by axis and job
    logic                 axis_y;
    logic signed [WW-1:0] lo_w, hi_w, lo_q, hi_q, c_w, r_w, s_w, p_lo, p_hi;
    logic signed [WW-1:0] cmin, cmax, clast;
    logic signed [WW-1:0] a_v, a_cl, a_off, b_v, b_cl, b_off, b_mag, num_w;
    logic [ugsq_pkg::STEP_W-1:0] step;
    logic [DW-1:0] div_num;
    logic [SW-1:0] div_den;
    logic          div_busy;
    logic [DW-1:0] quo;

    assign axis_y = (i_cmd.job == ugsq_pkg::JOB_LAST_Y) || (i_cmd.job == ugsq_pkg::JOB_C0_Y) ||
                    (i_cmd.job == ugsq_pkg::JOB_C1_Y) || (i_cmd.job == ugsq_pkg::JOB_WMN_Y) ||
                    (i_cmd.job == ugsq_pkg::JOB_WMX_Y);

    assign step  = axis_y ? r_step_y : r_step_x;
    assign lo_w  = WW'(axis_y ? r_min_y : r_min_x);
    assign hi_w  = WW'(axis_y ? r_max_y : r_max_x);
    assign lo_q  = lo_w <<< FRAC_BITS;
    assign hi_q  = hi_w <<< FRAC_BITS;
    assign c_w   = WW'(axis_y ? r_qy : r_qx);
    assign r_w   = WW'(r_qr);
    assign s_w   = WW'(step);
    assign p_lo  = WW'(axis_y ? by_lo : bx_lo) - lo_w;
    assign p_hi  = WW'(axis_y ? by_hi : bx_hi) - lo_w;
    assign cmin  = axis_y ? r_c0_y : r_c0_x;
    assign cmax  = axis_y ? r_c1_y : r_c1_x;
    assign clast = axis_y ? r_last_y : r_last_x;

    assign a_v   = c_w - r_w;
    assign a_cl  = (a_v < lo_q) ? lo_q : a_v;
    assign a_off = a_cl - lo_q;
    assign b_v   = c_w + r_w;
    assign b_cl  = (b_v > hi_q) ? hi_q : b_v;
    assign b_off = b_cl - lo_q;
    assign b_mag = b_off[WW-1] ? -b_off : b_off;

    always_comb begin
        num_w   = hi_w - lo_w;
        div_den = SW'(step);
        case (i_cmd.job)
            ugsq_pkg::JOB_C0_X, ugsq_pkg::JOB_C0_Y: begin
                num_w   = a_off;
                div_den = SW'(step) << FRAC_BITS;
            end
            ugsq_pkg::JOB_C1_X, ugsq_pkg::JOB_C1_Y: begin
                num_w   = b_mag;
                div_den = SW'(step) << FRAC_BITS;
            end
            ugsq_pkg::JOB_WMN_X, ugsq_pkg::JOB_WMN_Y: num_w = p_lo + s_w - WW'(1);
            ugsq_pkg::JOB_WMX_X, ugsq_pkg::JOB_WMX_Y: num_w = p_hi;
            default: num_w = hi_w - lo_w;
        endcase
    end
    assign div_num = num_w[DW-1:0];

    ugsq_div #(.DW(DW), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // Capture arithmetic
    logic signed [WW-1:0] q_w, c1_v, f_v, f_a, f_b, fin;
    assign q_w  = WW'(quo);
    assign c1_v = r_neg ? ((quo == '0) ? '0 : -WW'(1)) : q_w;
    assign f_v  = q_w - WW'(1);
    assign f_a  = (f_v < 0) ? '0 : f_v;
    assign f_b  = (f_a < cmin) ? cmin : f_a;
    assign fin  = (q_w > cmax) ? cmax : q_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= b_off[WW-1];
        end
        if (i_cmd.cap) begin
            case (i_cmd.job)
                ugsq_pkg::JOB_LAST_X: r_last_x <= q_w;
                ugsq_pkg::JOB_LAST_Y: r_last_y <= q_w;
                ugsq_pkg::JOB_C0_X:   r_c0_x <= q_w;
                ugsq_pkg::JOB_C0_Y:   r_c0_y <= q_w;
                ugsq_pkg::JOB_C1_X:   r_c1_x <= (c1_v > clast) ? clast : c1_v;
                ugsq_pkg::JOB_C1_Y:   r_c1_y <= (c1_v > clast) ? clast : c1_v;
                ugsq_pkg::JOB_WMN_X, ugsq_pkg::JOB_WMN_Y: r_wfirst <= f_b;
                ugsq_pkg::JOB_WMX_X: begin
                    r_fx  <= r_wfirst;
                    r_okx <= (r_wfirst <= fin);
                end
                default: begin
                    r_fy  <= r_wfirst;
                    r_oky <= (r_wfirst <= fin);
                end
            endcase
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem_wall[r_count[IW-1:0]] <= {i_wall_x1, i_wall_y1, i_wall_x2, i_wall_y2};
        end
        r_rd <= mem_wall[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wall_wr) begin
            mem_key[r_idx[IW-1:0]] <= {r_fx[CW-1:0], r_fy[CW-1:0]};
        end
        r_kd <= mem_key[r_idx[IW-1:0]];
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x <= ugsq_pkg::STEP_RESET;
            r_step_y <= ugsq_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ugsq_pkg::CFG_STEP_X: r_step_x <= i_cfg_wdata;
                default:              r_step_y <= i_cfg_wdata;
            endcase
        end
    end

    // Store bookkeeping and box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_built <= 1'b0;
            r_drop  <= 1'b0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_built <= 1'b0;
                r_drop  <= 1'b0;
                r_min_x <= '0;
                r_max_x <= '0;
                r_min_y <= '0;
                r_max_y <= '0;
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_built <= 1'b0;
                end
            end
            if (i_cmd.unbuild) begin
                r_built <= 1'b0;
            end
            if (i_cmd.build_start) begin
                r_built <= 1'b0;
                r_min_x <= '0;
                r_max_x <= '0;
                r_min_y <= '0;
                r_max_y <= '0;
            end
            if (i_cmd.box_upd) begin
                if (r_idx == '0) begin
                    r_min_x <= bx_lo;
                    r_max_x <= bx_hi;
                    r_min_y <= by_lo;
                    r_max_y <= by_hi;
                end else begin
                    r_min_x <= (bx_lo < r_min_x) ? bx_lo : r_min_x;
                    r_max_x <= (bx_hi > r_max_x) ? bx_hi : r_max_x;
                    r_min_y <= (by_lo < r_min_y) ? by_lo : r_min_y;
                    r_max_y <= (by_hi > r_max_y) ? by_hi : r_max_y;
                end
            end
            if (i_cmd.build_done) begin
                r_built <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_latch) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
            r_qr <= i_query_radius;
        end
    end

    // Walk index, pending set and best-so-far of the emission scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_npend   <= '0;
            r_pend    <= '0;
            r_best_ok <= 1'b0;
        end else begin
            if (i_cmd.build_start || i_cmd.q_latch || i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.box_upd || i_cmd.wall_wr || i_cmd.scan_cmp) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.q_latch) begin
                r_pend  <= '0;
                r_npend <= '0;
            end
            if (i_cmd.wall_wr) begin
                r_pend[r_idx[IW-1:0]] <= r_okx && r_oky;
                if (r_okx && r_oky) begin
                    r_npend <= r_npend + 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_best_ok <= 1'b0;
            end
            if (i_cmd.scan_cmp && r_pend[r_idx[IW-1:0]] &&
                (!r_best_ok || (r_kd < r_best_key))) begin
                r_best_ok <= 1'b1;
            end
            if (i_cmd.emit_hit) begin
                r_pend[r_best_idx] <= 1'b0;
                r_npend <= r_npend - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cmp && r_pend[r_idx[IW-1:0]] &&
            (!r_best_ok || (r_kd < r_best_key))) begin
            r_best_key <= r_kd;
            r_best_idx <= r_idx[IW-1:0];
        end
    end

    // Result register
    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_hit || i_cmd.emit_empty) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit) begin
            o_wall_index <= ugsq_pkg::OUT_IDX_W'(r_best_idx);
            o_found      <= 1'b1;
            o_overflowed <= r_drop;
            o_last       <= (r_npend == CNTW'(1));
        end else if (i_cmd.emit_empty) begin
            o_wall_index <= '0;
            o_found      <= 1'b0;
            o_overflowed <= r_drop;
            o_last       <= 1'b1;
        end
    end

    assign o_stat.idx_end    = (r_idx == r_count);
    assign o_stat.steps_ok   = (r_step_x != '0) && (r_step_y != '0);
    assign o_stat.query_ok   = r_built && (r_step_x != '0) && (r_step_y != '0) &&
                               (r_count != '0);
    assign o_stat.div_busy   = div_busy;
    assign o_stat.npend_zero = (r_npend == '0);
    assign o_stat.last_one   = (r_npend == CNTW'(1));
    assign o_stat.out_free   = out_free;
endmodule
`default_nettype wire
